FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the tokenizer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: hdl/ast_pkg.sv
// ---------------------------------------------------------------------------
// ast_pkg
// types, character codes and classifiers for the source tokenizer
// ---------------------------------------------------------------------------
package ast_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // token kinds
   localparam logic [3:0] K_END   = 4'd0;
   localparam logic [3:0] K_NL    = 4'd1;
   localparam logic [3:0] K_IDENT = 4'd2;
   localparam logic [3:0] K_INT   = 4'd3;
   localparam logic [3:0] K_LREF  = 4'd4;
   localparam logic [3:0] K_STR   = 4'd5;
   localparam logic [3:0] K_LSH   = 4'd6;
   localparam logic [3:0] K_RSH   = 4'd7;
   localparam logic [3:0] K_PUNCT = 4'd8;
   localparam logic [3:0] K_TEXT  = 4'd9;

   // characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOL   = 8'h24;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_UND   = 8'h5F;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_LF_CH = 8'h66;
   localparam logic [7:0] CH_LN    = 8'h6E;
   localparam logic [7:0] CH_LR    = 8'h72;
   localparam logic [7:0] CH_LT_CH = 8'h74;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   // one lexer step handed from front to back
   typedef struct packed {
      logic       rep_end;    // stream already ended: repeat end token
      logic       step_last;  // final lexer call of this beat
      logic [7:0] c;
      logic [7:0] a1;
      logic [7:0] a2;
   } ast_entry_type;

   function automatic logic dec_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return dec_digit(c) || ((c >= CH_LA) && (c <= CH_LF_CH)) ||
             ((c >= CH_UA) && (c <= CH_UF));
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      if (dec_digit(c)) begin
         v = c[3:0];
      end else begin
         v = 4'(c[3:0] + 4'd9);
      end
      return v;
   endfunction

   function automatic logic id_start(input logic [7:0] c);
      return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
             (c == CH_UND) || (c == CH_DOT);
   endfunction

   function automatic logic id_char(input logic [7:0] c);
      return id_start(c) || dec_digit(c) || (c == CH_DOL);
   endfunction

   // {hit, byte} for the simple escapes
   function automatic logic [8:0] esc_map(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         CH_LB:    r = {1'b1, 8'h08};
         CH_LF_CH: r = {1'b1, 8'h0C};
         CH_LN:    r = {1'b1, 8'h0A};
         CH_LR:    r = {1'b1, 8'h0D};
         CH_LT_CH: r = {1'b1, 8'h09};
         CH_BSL:   r = {1'b1, c};
         CH_DQ:    r = {1'b1, c};
         CH_SQ:    r = {1'b1, c};
         default:  r = {1'b0, 8'h00};
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/ast_chan_if.sv
// ---------------------------------------------------------------------------
// tokenizer channels
// request, response and register-write handshake bundles
// ---------------------------------------------------------------------------
interface ast_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_byte;
   logic       end_of_source;
   modport source (output valid, src_byte, end_of_source, input ready);
   modport sink   (input valid, src_byte, end_of_source, output ready);
endinterface

interface ast_rsp_if #(parameter int LINE_BITS = 20, parameter int COL_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [3:0]           token_kind;
   logic [63:0]          token_value;
   logic [LINE_BITS-1:0] token_line;
   logic [COL_BITS-1:0]  token_col;
   logic [7:0]           char_byte;
   logic                 backward_ref;
   logic                 last_of_run;
   modport source (output valid, token_kind, token_value, token_line, token_col,
                   char_byte, backward_ref, last_of_run, input ready);
   modport sink   (input valid, token_kind, token_value, token_line, token_col,
                   char_byte, backward_ref, last_of_run, output ready);
endinterface

interface ast_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/assembler_source_tokenizer.sv
// ---------------------------------------------------------------------------
// assembler_source_tokenizer
// assembly source lexer: bytes in, tokens and text bytes out
// ---------------------------------------------------------------------------
//  channel   dir  beat contents
//  req_bus   in   src_byte, end_of_source
//  rsp_bus   out  token_kind, token_value, token_line, token_col, char_byte,
//                 backward_ref, last_of_run
//  csr_bus   in   hash_comments_anywhere (one bit, always ready)
//
//  one input beat per cycle while the step queue has room and each byte gives
//  at most one result; every extra result of a byte, and every chained mode
//  step, takes another step of the lexer state machine, which runs one mode
//  step per cycle; an end beat drains the window, a lexer call per byte, then
//  a closing call; synchronous active-high reset; the step queue decouples
//  input and output stalls; a stalled output register freezes the lexer
// ---------------------------------------------------------------------------
module assembler_source_tokenizer #(
   parameter int LINE_BITS = 20,
   parameter int COL_BITS  = 16
) (
   input  logic           clock,
   input  logic           reset,
   ast_req_if.sink        req_bus,
   ast_rsp_if.source      rsp_bus,
   ast_csr_if.sink        csr_bus
);

   // comment-anywhere control register
   logic hash_ff;

   // front to queue
   logic                   q_push, q_ready;
   ast_pkg::ast_entry_type q_entry;

   // queue to lexer
   logic                   h_valid, h_pop;
   ast_pkg::ast_entry_type h_entry;

   logic [LINE_BITS-1:0]   line_w;
   logic [COL_BITS-1:0]    col_w;

   // register write port never stalls
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         hash_ff <= csr_bus.data;
      end
   end

   // window and drain sequencing
   ast_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .src_byte      (req_bus.src_byte),
      .end_of_source (req_bus.end_of_source),
      .q_ready       (q_ready),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   // lexer steps waiting for the back end
   ast_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .push_ready (q_ready),
      .pop        (h_pop),
      .head_valid (h_valid),
      .head_entry (h_entry)
   );

   // mode machine, accumulators and result register
   ast_lexer #(
      .LINE_BITS (LINE_BITS),
      .COL_BITS  (COL_BITS)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .hash_any  (hash_ff),
      .ent_valid (h_valid),
      .ent       (h_entry),
      .ent_pop   (h_pop),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_kind  (rsp_bus.token_kind),
      .rsp_value (rsp_bus.token_value),
      .rsp_line  (line_w),
      .rsp_col   (col_w),
      .rsp_char  (rsp_bus.char_byte),
      .rsp_back  (rsp_bus.backward_ref),
      .rsp_last  (rsp_bus.last_of_run)
   );

   assign rsp_bus.token_line = line_w;
   assign rsp_bus.token_col  = col_w;

endmodule

FILE: hdl/ast_front.sv
// ---------------------------------------------------------------------------
// ast_front
// lookahead window, end-of-source drain and step queue feed
// ---------------------------------------------------------------------------
module ast_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             src_byte,
   input  logic                   end_of_source,
   input  logic                   q_ready,
   output logic                   q_push,
   output ast_pkg::ast_entry_type q_entry
);

   logic [7:0] w0_ff, w0_in, w1_ff, w1_in;
   logic [1:0] fill_ff, fill_in;
   logic [1:0] drain_ff, drain_in;
   logic       done_ff, done_in;
   logic       acc, fin;

   assign req_ready = q_ready && (drain_ff == 2'd0);
   assign acc       = req_valid && req_ready;
   assign fin       = end_of_source || (src_byte == ast_pkg::CH_NUL);

   always_comb begin
      w0_in    = w0_ff;
      w1_in    = w1_ff;
      fill_in  = fill_ff;
      drain_in = drain_ff;
      done_in  = done_ff;
      q_push   = 1'b0;
      q_entry  = '0;
      if (drain_ff != 2'd0) begin
         // empty the window one lexer call per cycle while the queue has room, then the closing call
         q_entry.step_last = (drain_ff == 2'd1);
         q_entry.c         = (fill_ff != 2'd0) ? w0_ff : ast_pkg::CH_NUL;
         q_entry.a1        = (fill_ff == 2'd2) ? w1_ff : ast_pkg::CH_NUL;
         if (q_ready) begin
            q_push   = 1'b1;
            w0_in    = w1_ff;
            w1_in    = ast_pkg::CH_NUL;
            fill_in  = (fill_ff != 2'd0) ? 2'(fill_ff - 2'd1) : 2'd0;
            drain_in = 2'(drain_ff - 2'd1);
         end
      end else if (acc) begin
         if (done_ff) begin
            q_push            = 1'b1;
            q_entry.rep_end   = 1'b1;
            q_entry.step_last = 1'b1;
         end else if (fin) begin
            done_in  = 1'b1;
            drain_in = 2'(fill_ff + 2'd1);
         end else if (fill_ff == 2'd0) begin
            w0_in   = src_byte;
            fill_in = 2'd1;
         end else if (fill_ff == 2'd1) begin
            w1_in   = src_byte;
            fill_in = 2'd2;
         end else begin
            q_push            = 1'b1;
            q_entry.step_last = 1'b1;
            q_entry.c         = w0_ff;
            q_entry.a1        = w1_ff;
            q_entry.a2        = src_byte;
            w0_in             = w1_ff;
            w1_in             = src_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w0_ff    <= '0;
         w1_ff    <= '0;
         fill_ff  <= '0;
         drain_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         w0_ff    <= w0_in;
         w1_ff    <= w1_in;
         fill_ff  <= fill_in;
         drain_ff <= drain_in;
         done_ff  <= done_in;
      end
   end

endmodule

FILE: hdl/ast_fifo.sv
// ---------------------------------------------------------------------------
// ast_fifo
// short step queue between front and lexer back end
// ---------------------------------------------------------------------------
module ast_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ast_pkg::ast_entry_type push_entry,
   output logic                   push_ready,
   input  logic                   pop,
   output logic                   head_valid,
   output ast_pkg::ast_entry_type head_entry
);

   ast_pkg::ast_entry_type              mem_ff [ast_pkg::QUEUE_DEPTH];
   logic [ast_pkg::QUEUE_AW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [ast_pkg::QUEUE_AW:0]          cnt_ff, cnt_in;

   assign push_ready = (cnt_ff != (ast_pkg::QUEUE_AW+1)'(ast_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = mem_ff[rd_ff];

   always_comb begin
      wr_in  = (push && push_ready) ? wr_ff + 1'b1 : wr_ff;
      rd_in  = (pop && head_valid) ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (ast_pkg::QUEUE_AW+1)'(push && push_ready)
                      - (ast_pkg::QUEUE_AW+1)'(pop && head_valid);
   end

   always_ff @(posedge clock) begin
      if (push && push_ready) begin
         mem_ff[wr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: hdl/ast_lexer.sv
// ---------------------------------------------------------------------------
// ast_lexer
// lexer state machine, one mode step per cycle while the output is not stalled, with result holding stage
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ast_lexer #(
   parameter int LINE_BITS = 20,
   parameter int COL_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   hash_any,
   input  logic                   ent_valid,
   input  ast_pkg::ast_entry_type ent,
   output logic                   ent_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_kind,
   output logic [63:0]            rsp_value,
   output logic [LINE_BITS-1:0]   rsp_line,
   output logic [COL_BITS-1:0]    rsp_col,
   output logic [7:0]             rsp_char,
   output logic                   rsp_back,
   output logic                   rsp_last
);

   localparam logic [4:0] M_IDLE = 5'd0,  M_DONE = 5'd1,  M_CONT = 5'd2,  M_LCOM = 5'd3;
   localparam logic [4:0] M_BOPEN = 5'd4, M_BLOCK = 5'd5, M_BCLOSE = 5'd6, M_SKIP1 = 5'd7;
   localparam logic [4:0] M_IDENT = 5'd8, M_HEXP = 5'd9,  M_HEX = 5'd10,  M_BINP = 5'd11;
   localparam logic [4:0] M_BIN = 5'd12,  M_DEC = 5'd13,  M_STR = 5'd14,  M_SESC = 5'd15;
   localparam logic [4:0] M_SHEX = 5'd16, M_SOCT = 5'd17, M_CHR = 5'd18,  M_CESC = 5'd19;
   localparam logic [4:0] M_CEND = 5'd20;

   // lexer state
   logic [4:0]           mode_ff, mode_in;
   logic [LINE_BITS-1:0] line_ff, line_in, sline_ff, sline_in;
   logic [COL_BITS-1:0]  col_ff, col_in, scol_ff, scol_in;
   logic [63:0]          num_ff, num_in, oct_ff, oct_in;
   logic                 lead0_ff, lead0_in, stmt_ff, stmt_in;
   logic [7:0]           esc_ff, esc_in, chr_ff, chr_in;
   logic [1:0]           edig_ff, edig_in;

   // pending result
   logic                 p_valid_ff, p_valid_in, p_fin_ff, p_fin_in;
   logic [3:0]           p_kind_ff, p_kind_in;
   logic [63:0]          p_value_ff, p_value_in;
   logic [LINE_BITS-1:0] p_line_ff, p_line_in;
   logic [COL_BITS-1:0]  p_col_ff, p_col_in;
   logic [7:0]           p_char_ff, p_char_in;
   logic                 p_back_ff, p_back_in;

   // output register
   logic                 o_valid_ff, o_valid_in, o_last_ff, o_last_in;
   logic [3:0]           o_kind_ff;
   logic [63:0]          o_value_ff;
   logic [LINE_BITS-1:0] o_line_ff;
   logic [COL_BITS-1:0]  o_col_ff;
   logic [7:0]           o_char_ff;
   logic                 o_back_ff;

   // step scratch
   logic                 out_free, iterate, ret, emit, do_adv, step_end, out_push;
   logic [3:0]           e_kind;
   logic [63:0]          e_value;
   logic [LINE_BITS-1:0] e_line;
   logic [COL_BITS-1:0]  e_col;
   logic [7:0]           e_char;
   logic                 e_back;
   logic [7:0]           c, a1, a2;
   logic [8:0]           em;
   logic [LINE_BITS-1:0] adv_line;
   logic [COL_BITS-1:0]  adv_col;

   assign c  = ent.c;
   assign a1 = ent.a1;
   assign a2 = ent.a2;
   assign em = ast_pkg::esc_map(c);

   // position update for the byte under the cursor, saturating
   always_comb begin
      if (c == ast_pkg::CH_LF) begin
         adv_line = (line_ff != '1) ? line_ff + 1'b1 : line_ff;
         adv_col  = COL_BITS'(1);
      end else begin
         adv_line = line_ff;
         adv_col  = (col_ff != '1) ? col_ff + 1'b1 : col_ff;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      num_in   = num_ff;
      oct_in   = oct_ff;
      lead0_in = lead0_ff;
      stmt_in  = stmt_ff;
      esc_in   = esc_ff;
      edig_in  = edig_ff;
      chr_in   = chr_ff;
      ret      = 1'b1;
      emit     = 1'b0;
      do_adv   = 1'b0;
      e_kind   = ast_pkg::K_END;
      e_value  = '0;
      e_line   = sline_ff;
      e_col    = scol_ff;
      e_char   = '0;
      e_back   = 1'b0;
      if (ent.rep_end) begin
         emit   = 1'b1;
         e_line = line_ff;
         e_col  = col_ff;
      end else begin
         case (mode_ff)
            M_IDLE: begin
               if (c == ast_pkg::CH_SP || c == ast_pkg::CH_TAB || c == ast_pkg::CH_CR) begin
                  do_adv = 1'b1;
               end else if (c == ast_pkg::CH_BSL && (a1 == ast_pkg::CH_LF ||
                            (a1 == ast_pkg::CH_CR && a2 == ast_pkg::CH_LF))) begin
                  do_adv  = 1'b1;
                  mode_in = M_CONT;
               end else if (c == ast_pkg::CH_SLASH && a1 == ast_pkg::CH_SLASH) begin
                  mode_in = M_LCOM;
                  ret     = 1'b0;
               end else if (c == ast_pkg::CH_SLASH && a1 == ast_pkg::CH_STAR) begin
                  do_adv  = 1'b1;
                  mode_in = M_BOPEN;
               end else if (c == ast_pkg::CH_HASH && (stmt_ff || hash_any)) begin
                  mode_in = M_LCOM;
                  ret     = 1'b0;
               end else if (c == ast_pkg::CH_NUL) begin
                  emit    = 1'b1;
                  e_line  = line_ff;
                  e_col   = col_ff;
                  mode_in = M_DONE;
               end else if (c == ast_pkg::CH_LF || c == ast_pkg::CH_SEMI) begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_NL;
                  e_line  = line_ff;
                  e_col   = col_ff;
                  do_adv  = 1'b1;
                  stmt_in = 1'b1;
               end else begin
                  stmt_in  = 1'b0;
                  sline_in = line_ff;
                  scol_in  = col_ff;
                  e_line   = line_ff;
                  e_col    = col_ff;
                  if (ast_pkg::id_start(c)) begin
                     emit    = 1'b1;
                     e_kind  = ast_pkg::K_TEXT;
                     e_char  = c;
                     do_adv  = 1'b1;
                     mode_in = M_IDENT;
                  end else if (ast_pkg::dec_digit(c)) begin
                     num_in = '0;
                     oct_in = '0;
                     if (c == ast_pkg::CH_ZERO && (a1 == ast_pkg::CH_LX ||
                         a1 == ast_pkg::CH_UX) && ast_pkg::is_hex(a2)) begin
                        do_adv  = 1'b1;
                        mode_in = M_HEXP;
                     end else if (c == ast_pkg::CH_ZERO && (a1 == ast_pkg::CH_LB ||
                                  a1 == ast_pkg::CH_UB) &&
                                  (a2 == ast_pkg::CH_ZERO || a2 == ast_pkg::CH_ONE)) begin
                        do_adv  = 1'b1;
                        mode_in = M_BINP;
                     end else begin
                        lead0_in = (c == ast_pkg::CH_ZERO);
                        mode_in  = M_DEC;
                        ret      = 1'b0;
                     end
                  end else if (c == ast_pkg::CH_DQ) begin
                     do_adv  = 1'b1;
                     mode_in = M_STR;
                  end else if (c == ast_pkg::CH_SQ) begin
                     do_adv  = 1'b1;
                     chr_in  = '0;
                     mode_in = M_CHR;
                  end else if (c == ast_pkg::CH_LT && a1 == ast_pkg::CH_LT) begin
                     emit    = 1'b1;
                     e_kind  = ast_pkg::K_LSH;
                     do_adv  = 1'b1;
                     mode_in = M_SKIP1;
                  end else if (c == ast_pkg::CH_GT && a1 == ast_pkg::CH_GT) begin
                     emit    = 1'b1;
                     e_kind  = ast_pkg::K_RSH;
                     do_adv  = 1'b1;
                     mode_in = M_SKIP1;
                  end else begin
                     emit   = 1'b1;
                     e_kind = ast_pkg::K_PUNCT;
                     e_char = c;
                     do_adv = 1'b1;
                  end
               end
            end
            M_LCOM: begin
               if (c == ast_pkg::CH_LF || c == ast_pkg::CH_NUL) begin
                  mode_in = M_IDLE;
                  ret     = 1'b0;
               end else begin
                  do_adv = 1'b1;
               end
            end
            M_CONT: begin
               if (c == ast_pkg::CH_NUL) begin
                  mode_in = M_IDLE;
                  ret     = 1'b0;
               end else begin
                  do_adv = 1'b1;
                  if (c == ast_pkg::CH_LF) begin
                     mode_in = M_IDLE;
                  end
               end
            end
            M_BOPEN, M_HEXP, M_BINP: begin
               if (mode_ff == M_BOPEN) begin
                  mode_in = M_BLOCK;
               end else if (mode_ff == M_HEXP) begin
                  mode_in = M_HEX;
               end else begin
                  mode_in = M_BIN;
               end
               if (c == ast_pkg::CH_NUL) begin
                  ret = 1'b0;
               end else begin
                  do_adv = 1'b1;
               end
            end
            M_BLOCK: begin
               if (c == ast_pkg::CH_NUL) begin
                  mode_in = M_IDLE;
                  ret     = 1'b0;
               end else if (c == ast_pkg::CH_STAR && a1 == ast_pkg::CH_SLASH) begin
                  do_adv  = 1'b1;
                  mode_in = M_BCLOSE;
               end else begin
                  do_adv = 1'b1;
               end
            end
            M_BCLOSE, M_SKIP1: begin
               mode_in = M_IDLE;
               if (c == ast_pkg::CH_NUL) begin
                  ret = 1'b0;
               end else begin
                  do_adv = 1'b1;
               end
            end
            M_IDENT: begin
               emit = 1'b1;
               if (ast_pkg::id_char(c)) begin
                  e_kind = ast_pkg::K_TEXT;
                  e_char = c;
                  do_adv = 1'b1;
               end else begin
                  e_kind  = ast_pkg::K_IDENT;
                  mode_in = M_IDLE;
                  ret     = 1'b0;
               end
            end
            M_HEX: begin
               if (ast_pkg::is_hex(c)) begin
                  num_in = {num_ff[59:0], ast_pkg::hex_val(c)};
                  do_adv = 1'b1;
               end else begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_INT;
                  e_value = num_ff;
                  mode_in = M_IDLE;
                  ret     = 1'b0;
               end
            end
            M_BIN: begin
               if (c == ast_pkg::CH_ZERO || c == ast_pkg::CH_ONE) begin
                  num_in = {num_ff[62:0], c[0]};
                  do_adv = 1'b1;
               end else begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_INT;
                  e_value = num_ff;
                  mode_in = M_IDLE;
                  ret     = 1'b0;
               end
            end
            M_DEC: begin
               if (ast_pkg::dec_digit(c)) begin
                  num_in = {num_ff[60:0], 3'b000} + {num_ff[62:0], 1'b0} + 64'(c[3:0]);
                  oct_in = {oct_ff[60:0], 3'b000} + 64'(c[3:0]);
                  do_adv = 1'b1;
               end else if ((c == ast_pkg::CH_LB || c == ast_pkg::CH_LF_CH) &&
                            !ast_pkg::id_char(a1)) begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_LREF;
                  e_value = num_ff;
                  e_back  = (c == ast_pkg::CH_LB);
                  do_adv  = 1'b1;
                  mode_in = M_IDLE;
               end else begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_INT;
                  e_value = lead0_ff ? oct_ff : num_ff;
                  mode_in = M_IDLE;
                  ret     = 1'b0;
               end
            end
            M_STR: begin
               if (c == ast_pkg::CH_DQ) begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_STR;
                  do_adv  = 1'b1;
                  mode_in = M_IDLE;
               end else if (c == ast_pkg::CH_LF || c == ast_pkg::CH_NUL) begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_STR;
                  mode_in = M_IDLE;
                  ret     = 1'b0;
               end else if (c == ast_pkg::CH_BSL) begin
                  do_adv  = 1'b1;
                  mode_in = M_SESC;
               end else begin
                  emit   = 1'b1;
                  e_kind = ast_pkg::K_TEXT;
                  e_char = c;
                  do_adv = 1'b1;
               end
            end
            M_SESC: begin
               if (em[8]) begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_TEXT;
                  e_char  = em[7:0];
                  do_adv  = 1'b1;
                  mode_in = M_STR;
               end else if (c == ast_pkg::CH_LX) begin
                  do_adv  = 1'b1;
                  esc_in  = '0;
                  mode_in = M_SHEX;
               end else if (c >= ast_pkg::CH_ZERO && c <= ast_pkg::CH_SEVEN) begin
                  esc_in  = '0;
                  edig_in = '0;
                  mode_in = M_SOCT;
                  ret     = 1'b0;
               end else begin
                  // any other escaped byte stands for itself
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_TEXT;
                  e_char  = c;
                  mode_in = M_STR;
                  if (c == ast_pkg::CH_NUL) begin
                     ret = 1'b0;
                  end else begin
                     do_adv = 1'b1;
                  end
               end
            end
            M_SHEX: begin
               if (ast_pkg::is_hex(c)) begin
                  esc_in = {esc_ff[3:0], ast_pkg::hex_val(c)};
                  do_adv = 1'b1;
               end else begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_TEXT;
                  e_char  = esc_ff;
                  mode_in = M_STR;
                  ret     = 1'b0;
               end
            end
            M_SOCT: begin
               if (edig_ff != 2'd3 && c >= ast_pkg::CH_ZERO && c <= ast_pkg::CH_SEVEN) begin
                  esc_in  = {esc_ff[4:0], c[2:0]};
                  edig_in = edig_ff + 1'b1;
                  do_adv  = 1'b1;
               end else begin
                  emit    = 1'b1;
                  e_kind  = ast_pkg::K_TEXT;
                  e_char  = esc_ff;
                  mode_in = M_STR;
                  ret     = 1'b0;
               end
            end
            M_CHR: begin
               if (c == ast_pkg::CH_BSL) begin
                  do_adv  = 1'b1;
                  mode_in = M_CESC;
               end else begin
                  chr_in  = c;
                  mode_in = M_CEND;
                  if (c != ast_pkg::CH_NUL && c != ast_pkg::CH_LF) begin
                     do_adv = 1'b1;
                  end else begin
                     ret = 1'b0;
                  end
               end
            end
            M_CESC: begin
               if (em[8]) begin
                  chr_in = em[7:0];
               end else if (c == ast_pkg::CH_ZERO) begin
                  chr_in = '0;
               end else begin
                  chr_in = c;
               end
               mode_in = M_CEND;
               if (c == ast_pkg::CH_NUL) begin
                  ret = 1'b0;
               end else begin
                  do_adv = 1'b1;
               end
            end
            M_CEND: begin
               emit    = 1'b1;
               e_kind  = ast_pkg::K_INT;
               e_value = 64'(chr_ff);
               mode_in = M_IDLE;
               if (c == ast_pkg::CH_SQ) begin
                  do_adv = 1'b1;
               end else begin
                  ret = 1'b0;
               end
            end
            M_DONE: begin
               ret = 1'b1;
            end
            default: begin
               mode_in = M_IDLE;
               ret     = 1'b0;
            end
         endcase
      end
   end

   assign line_in = do_adv ? adv_line : line_ff;
   assign col_in  = do_adv ? adv_col  : col_ff;

   // result sequencing: a result is held until the next one, or the end of
   // its beat, tells whether it closes the beat
   assign out_free = !o_valid_ff || rsp_ready;
   assign iterate  = out_free && ent_valid;
   assign ent_pop  = iterate && ret;
   assign step_end = iterate && ret && ent.step_last;
   assign out_push = out_free && p_valid_ff &&
                     (p_fin_ff || (iterate && emit) || step_end);

   always_comb begin
      p_valid_in = p_valid_ff;
      p_fin_in   = p_fin_ff;
      p_kind_in  = p_kind_ff;
      p_value_in = p_value_ff;
      p_line_in  = p_line_ff;
      p_col_in   = p_col_ff;
      p_char_in  = p_char_ff;
      p_back_in  = p_back_ff;
      if (iterate && emit) begin
         p_valid_in = 1'b1;
         p_fin_in   = step_end;
         p_kind_in  = e_kind;
         p_value_in = e_value;
         p_line_in  = e_line;
         p_col_in   = e_col;
         p_char_in  = e_char;
         p_back_in  = e_back;
      end else if (out_push) begin
         p_valid_in = 1'b0;
         p_fin_in   = 1'b0;
      end
      o_valid_in = out_push ? 1'b1 : (rsp_ready ? 1'b0 : o_valid_ff);
      o_last_in  = p_fin_ff || (!(iterate && emit) && step_end);
   end

   always_ff @(posedge clock) begin
      if (iterate) begin
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         num_ff   <= num_in;
         oct_ff   <= oct_in;
         lead0_ff <= lead0_in;
         esc_ff   <= esc_in;
         edig_ff  <= edig_in;
         chr_ff   <= chr_in;
      end
      p_kind_ff  <= p_kind_in;
      p_value_ff <= p_value_in;
      p_line_ff  <= p_line_in;
      p_col_ff   <= p_col_in;
      p_char_ff  <= p_char_in;
      p_back_ff  <= p_back_in;
      if (out_push) begin
         o_kind_ff  <= p_kind_ff;
         o_value_ff <= p_value_ff;
         o_line_ff  <= p_line_ff;
         o_col_ff   <= p_col_ff;
         o_char_ff  <= p_char_ff;
         o_back_ff  <= p_back_ff;
         o_last_ff  <= o_last_in;
      end
      if (reset) begin
         mode_ff    <= M_IDLE;
         line_ff    <= LINE_BITS'(1);
         col_ff     <= COL_BITS'(1);
         stmt_ff    <= 1'b1;
         p_valid_ff <= 1'b0;
         p_fin_ff   <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (iterate) begin
            mode_ff <= mode_in;
            line_ff <= line_in;
            col_ff  <= col_in;
            stmt_ff <= stmt_in;
         end
         p_valid_ff <= p_valid_in;
         p_fin_ff   <= p_fin_in;
         o_valid_ff <= o_valid_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_kind  = o_kind_ff;
   assign rsp_value = o_value_ff;
   assign rsp_line  = o_line_ff;
   assign rsp_col   = o_col_ff;
   assign rsp_char  = o_char_ff;
   assign rsp_back  = o_back_ff;
   assign rsp_last  = o_last_ff;

   `ASSERT_NEVER(a_fin_needs_valid, clock, reset, p_fin_ff && !p_valid_ff)
   `ASSERT_CLK(a_done_sticky, clock, reset, (mode_ff == M_DONE) |=> (mode_ff == M_DONE))
   `ASSERT_CLK(a_pend_holds, clock, reset, (p_valid_ff && !out_free) |=> (p_valid_ff && $stable(p_kind_ff) && $stable(p_value_ff)))
   `ASSERT_CLK(a_stall_no_step, clock, reset, (o_valid_ff && !rsp_ready) |-> !ent_pop)

endmodule
